FILE: src/spit_pkg.sv
// ----------------------------------------------------------------------------
// spit_pkg
// shared types, codes and defaults for the sorted priority insert table
// ----------------------------------------------------------------------------
`default_nettype none

package spit_pkg;

    // default number of table cells
    localparam int CAPACITY_DEF = 128;

    // field widths
    localparam int KEY_W    = 16;
    localparam int ID_W     = 16;
    localparam int HANDLE_W = 7;
    localparam int INDEX_W  = 7;
    localparam int COUNT_W  = 8;

    // read path: positions reachable by an index, and cells per read group
    localparam int READ_SPAN  = 2 ** INDEX_W;
    localparam int GROUP_SIZE = 16;
    localparam int GROUP_W    = $clog2(GROUP_SIZE);
    localparam int GROUPS     = READ_SPAN / GROUP_SIZE;
    localparam int GROUP_SEL_W = INDEX_W - GROUP_W;

    // function codes
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_READ   = 1'b1;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [ID_W-1:0]         id;
        logic [HANDLE_W-1:0]     handle;
    } entry_t;

    // what a cell tells its right-hand neighbor
    typedef struct packed {
        logic occ;  // cell holds an entry
        logic gt;   // held entry moves behind the new one
    } cell_link_t;

    typedef struct packed {
        logic                    func;
        logic signed [KEY_W-1:0] urgency_days;
        logic [ID_W-1:0]         loan_id;
        logic [HANDLE_W-1:0]     loan_handle;
        logic [INDEX_W-1:0]      read_index;
    } in_word_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] out_key;
        logic [ID_W-1:0]         out_id;
        logic [HANDLE_W-1:0]     out_handle;
        logic                    index_valid;
        logic                    insert_dropped;
        logic [COUNT_W-1:0]      entry_count;
    } out_word_t;

endpackage

`default_nettype wire

FILE: src/spit_in_if.sv
// ----------------------------------------------------------------------------
// spit_in_if
// valid/ready channel carrying one table operation word
// ----------------------------------------------------------------------------
`default_nettype none

interface spit_in_if;
    logic              valid;
    logic              ready;
    spit_pkg::in_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: src/spit_out_if.sv
// ----------------------------------------------------------------------------
// spit_out_if
// valid/ready channel carrying one result word
// ----------------------------------------------------------------------------
`default_nettype none

interface spit_out_if;
    logic               valid;
    logic               ready;
    spit_pkg::out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: src/spit_cell.sv
// ----------------------------------------------------------------------------
// spit_cell
// one compare-and-shift cell of the sorted table
// ----------------------------------------------------------------------------
`default_nettype none

module spit_cell (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                ins_en,
    input  wire spit_pkg::entry_t    new_entry,
    input  wire spit_pkg::entry_t    prev_entry,
    input  wire spit_pkg::cell_link_t prev_link,
    output spit_pkg::entry_t         entry,
    output spit_pkg::cell_link_t     link
);

    spit_pkg::entry_t entry_reg;
    spit_pkg::entry_t entry_next;
    logic             occ_reg;
    logic             occ_next;
    logic             gt;

    // strict order on (key, id): equal pairs stay ahead of the new entry
    always_comb
    begin
        gt = occ_reg &&
             (($signed(entry_reg.key) > $signed(new_entry.key)) ||
              ((entry_reg.key == new_entry.key) && (entry_reg.id > new_entry.id)));
    end

    always_comb
    begin
        entry_next = entry_reg;
        occ_next   = occ_reg;
        if (ins_en)
        begin
            occ_next = occ_reg | prev_link.occ;
            if (prev_link.gt)
            begin
                entry_next = prev_entry;
            end
            else if (gt || (!occ_reg && prev_link.occ))
            begin
                entry_next = new_entry;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry    = entry_reg;
    assign link.occ = occ_reg;
    assign link.gt  = gt;

endmodule

`default_nettype wire

FILE: src/spit_read_sel.sv
// ----------------------------------------------------------------------------
// spit_read_sel
// two-step read selector over the cell row
// ----------------------------------------------------------------------------
`default_nettype none

module spit_read_sel #(
    parameter int CAPACITY = spit_pkg::CAPACITY_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          load,
    input  wire logic [spit_pkg::INDEX_W-1:0]  index,
    input  wire spit_pkg::entry_t              cells [CAPACITY],
    output spit_pkg::entry_t                   sel_entry
);

    spit_pkg::entry_t                           span [spit_pkg::READ_SPAN];
    spit_pkg::entry_t                           grp_reg [spit_pkg::GROUPS];
    logic [spit_pkg::GROUP_SEL_W-1:0]           grp_sel_reg;

    // positions past the table read as zero
    for (genvar j = 0; j < spit_pkg::READ_SPAN; j++)
    begin : g_span
        if (j < CAPACITY)
        begin : g_cell
            assign span[j] = cells[j];
        end
        else
        begin : g_pad
            assign span[j] = '0;
        end
    end

    // first step: pick within each group by the low index bits
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int g = 0; g < spit_pkg::GROUPS; g++)
            begin
                grp_reg[g] <= span[g * spit_pkg::GROUP_SIZE +
                                   int'(index[spit_pkg::GROUP_W-1:0])];
            end
            grp_sel_reg <= index[spit_pkg::INDEX_W-1:spit_pkg::GROUP_W];
        end
    end

    // second step: pick the group
    assign sel_entry = grp_reg[grp_sel_reg];

endmodule

`default_nettype wire

FILE: src/sorted_priority_insert_table.sv
// ----------------------------------------------------------------------------
// sorted_priority_insert_table
// table of entries kept in ascending (urgency, id) order in a row of cells
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake      word
//  --------  ---  -------------  ---------------------------------------------
//  in_ch     in   valid / ready  func, urgency_days, loan_id, loan_handle,
//                                read_index
//  out_ch    out  valid / ready  out_key, out_id, out_handle, index_valid,
//                                insert_dropped, entry_count
//
//  on an insert every cell compares its entry with the new one and shifts
//  or loads in the same edge, at which its result word is also registered
//  a read runs through the two-step selector over the cell row (a registered
//  pick within each group, then the group pick); no new word is taken in ST_READ
//  reset empties the table at once through the per-cell occupied bits
//  a stalled result word holds in the output register; a new word is taken
//  only while that register is empty or being drained
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_insert_table #(
    parameter int CAPACITY = spit_pkg::CAPACITY_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    spit_in_if.sink     in_ch,
    spit_out_if.source  out_ch
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((CNT_W > spit_pkg::INDEX_W) ? CNT_W : spit_pkg::INDEX_W) + 1;

    // control states
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic                 state_reg;
    logic                 state_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    spit_pkg::out_word_t  out_word_reg;
    spit_pkg::out_word_t  out_word_next;
    logic                 rd_valid_reg;
    logic                 rd_valid_next;

    logic                 accept;
    logic                 is_insert;
    logic                 full;
    logic                 ins_en;
    logic                 idx_ok;
    logic [CNT_W+7:0]     count_ext;
    logic [CNT_W+7:0]     count_next_ext;

    spit_pkg::entry_t     new_entry;
    spit_pkg::entry_t     cell_entry [CAPACITY];
    spit_pkg::cell_link_t cell_link [CAPACITY+1];
    spit_pkg::entry_t     sel_entry;

    // a word is taken only when idle and the result register can take a word
    assign in_ch.ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ch.ready);
    assign accept      = in_ch.valid && in_ch.ready;
    assign is_insert   = (in_ch.data.func == spit_pkg::FUNC_INSERT);
    assign full        = (count_reg == CNT_W'(CAPACITY));
    assign ins_en      = accept && is_insert && !full;

    assign new_entry.key    = in_ch.data.urgency_days;
    assign new_entry.id     = in_ch.data.loan_id;
    assign new_entry.handle = in_ch.data.loan_handle;

    // index must be below the count (count never exceeds the capacity)
    assign idx_ok = (CMP_W'(in_ch.data.read_index) < CMP_W'(count_reg));

    // head of the row always counts as occupied and never shifts
    assign cell_link[0].occ = 1'b1;
    assign cell_link[0].gt  = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            spit_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ins_en     (ins_en),
                .new_entry  (new_entry),
                .prev_entry (new_entry),
                .prev_link  (cell_link[0]),
                .entry      (cell_entry[0]),
                .link       (cell_link[1])
            );
        end
        else
        begin : g_body
            spit_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ins_en     (ins_en),
                .new_entry  (new_entry),
                .prev_entry (cell_entry[i-1]),
                .prev_link  (cell_link[i]),
                .entry      (cell_entry[i]),
                .link       (cell_link[i+1])
            );
        end
    end

    spit_read_sel #(
        .CAPACITY (CAPACITY)
    ) u_read_sel (
        .clk       (clk),
        .load      (accept && !is_insert),
        .index     (in_ch.data.read_index),
        .cells     (cell_entry),
        .sel_entry (sel_entry)
    );

    // result count field is the low byte of the count after the operation
    assign count_next     = ins_en ? (count_reg + CNT_W'(1)) : count_reg;
    assign count_ext      = {8'b0, count_reg};
    assign count_next_ext = {8'b0, count_next};

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        rd_valid_next  = rd_valid_reg;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (is_insert)
                    begin
                        out_word_next                = '0;
                        out_word_next.insert_dropped = full;
                        out_word_next.entry_count    = count_next_ext[7:0];
                        out_valid_next               = 1'b1;
                    end
                    else
                    begin
                        rd_valid_next = idx_ok;
                        state_next    = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                // selector output is settled; the result register is empty here
                out_word_next             = '0;
                out_word_next.entry_count = count_ext[7:0];
                if (rd_valid_reg)
                begin
                    out_word_next.out_key     = sel_entry.key;
                    out_word_next.out_id      = sel_entry.id;
                    out_word_next.out_handle  = sel_entry.handle;
                    out_word_next.index_valid = 1'b1;
                end
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
        rd_valid_reg <= rd_valid_next;
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_word_reg;

endmodule

`default_nettype wire
